// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted.
`define RSH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Concurrent assertion that is checked in reset too.
`define RSH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/rsh_pkg.sv =====
package rsh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIST_W    = 32;

  localparam logic signed [DIST_W-1:0] DIST_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN  = 32'sh8000_0000;
  localparam logic signed [DIST_W-1:0] MISS_DIST = 32'shFFFF_0000;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_e;

  // Control that rides along with each request through the back half.
  typedef struct packed {
    logic valid;
    logic miss;
  } ctl_t;

endpackage

// ===== rtl/rsh_dly.sv =====
module rsh_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] pipe_q [D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < D; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign d_o = pipe_q[D-1];

endmodule

// ===== rtl/rsh_mul.sv =====
module rsh_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  // The multiplier is consumed sixteen bits per stage, low chunk first.
  localparam int NC = (BW + 15) / 16;
  localparam int EW = NC * 16;
  localparam int PW = AW + EW;

  logic signed [AW-1:0] a_q   [NC];
  logic signed [EW-1:0] b_q   [NC];
  logic signed [PW-1:0] acc_q [NC];

  for (genvar j = 0; j < NC; j++) begin : g_stage
    logic signed [AW-1:0] a_in;
    logic signed [EW-1:0] b_in;
    logic signed [PW-1:0] acc_in;
    logic signed [16:0]   chunk;
    logic signed [AW+16:0] pp;
    logic signed [PW-1:0] acc_d;

    if (j == 0) begin : g_first
      assign a_in   = a_i;
      assign b_in   = EW'(b_i);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[j-1];
      assign b_in   = b_q[j-1];
      assign acc_in = acc_q[j-1];
    end

    if (j == NC - 1) begin : g_top
      assign chunk = 17'($signed(b_in[j*16 +: 16]));
    end else begin : g_low
      assign chunk = $signed({1'b0, b_in[j*16 +: 16]});
    end

    assign pp    = a_in * chunk;
    assign acc_d = acc_in + (PW'(pp) <<< (16 * j));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[j]   <= a_in;
        b_q[j]   <= b_in;
        acc_q[j] <= acc_d;
      end
    end
  end

  assign p_o = acc_q[NC-1][AW+BW-1:0];

endmodule

// ===== rtl/rsh_sqrt.sv =====
module rsh_sqrt #(
  parameter int QW = 132,
  parameter int XW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [QW-1:0]   q_i,
  input  logic [XW-1:0]   side_i,
  output logic [QW/2-1:0] root_o,
  output logic [XW-1:0]   side_o
);

  // One result bit per stage, most significant first.
  localparam int SW = QW / 2;
  localparam int RW = SW + 3;

  logic [QW-1:0] q_q    [SW];
  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [XW-1:0] side_q [SW];

  for (genvar i = 0; i < SW; i++) begin : g_step
    logic [QW-1:0] q_in;
    logic [RW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [XW-1:0] side_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d;
    logic [SW-1:0] root_d;
    logic          ge;

    if (i == 0) begin : g_first
      assign q_in    = q_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign q_in    = q_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem_sh = {rem_in[RW-3:0], q_in[2*(SW-1-i) +: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;
    assign root_d = {root_in[SW-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i]    <= q_in;
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i] <= '0;
      end else if (en_i) begin
        side_q[i] <= side_in;
      end
    end
  end

  assign root_o = root_q[SW-1];
  assign side_o = side_q[SW-1];

endmodule

// ===== rtl/rsh_div.sv =====
module rsh_div #(
  parameter int NW = 67,
  parameter int AW = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [NW-1:0]                       mag_i,
  input  logic                                neg_i,
  input  logic [AW-1:0]                       a_i,
  input  rsh_pkg::ctl_t                       ctl_i,
  output logic signed [rsh_pkg::DIST_W-1:0]   dist_o,
  output rsh_pkg::ctl_t                       ctl_o
);

  localparam int QB = rsh_pkg::DIST_W;
  localparam int FB = rsh_pkg::FRAC_BITS;
  localparam int XW = (NW > AW + FB) ? NW : AW + FB;
  localparam int RW = AW + 1;

  // Entry stage: the early overflow test and the first partial remainder.
  logic [XW-1:0] mag_ext;
  logic [XW-1:0] a_sh;
  logic          sat_d;

  assign mag_ext = XW'(mag_i);
  assign a_sh    = XW'(a_i) << FB;
  assign sat_d   = (mag_ext >= a_sh);

  logic [RW-1:0]   rem0_q;
  logic [QB-1:0]   lo0_q;
  logic [AW-1:0]   a0_q;
  logic            neg0_q;
  logic            sat0_q;
  rsh_pkg::ctl_t   ctl0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q <= RW'(mag_i >> FB);
      lo0_q  <= QB'(mag_i[FB-1:0]) << (QB - FB);
      a0_q   <= a_i;
      neg0_q <= neg_i;
      sat0_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (en_i) begin
      ctl0_q <= ctl_i;
    end
  end

  // Restoring division, one quotient bit per stage.
  logic [RW-1:0]   rem_q [QB];
  logic [QB-1:0]   quo_q [QB];
  logic [QB-1:0]   lo_q  [QB];
  logic [AW-1:0]   a_q   [QB];
  logic            neg_q [QB];
  logic            sat_q [QB];
  rsh_pkg::ctl_t   ctl_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [QB-1:0] quo_in;
    logic [QB-1:0] lo_in;
    logic [AW-1:0] a_in;
    logic          neg_in;
    logic          sat_in;
    rsh_pkg::ctl_t ctl_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] rem_d;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = rem0_q;
      assign quo_in = '0;
      assign lo_in  = lo0_q;
      assign a_in   = a0_q;
      assign neg_in = neg0_q;
      assign sat_in = sat0_q;
      assign ctl_in = ctl0_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign a_in   = a_q[j-1];
      assign neg_in = neg_q[j-1];
      assign sat_in = sat_q[j-1];
      assign ctl_in = ctl_q[j-1];
    end

    assign rem_sh = {rem_in[AW-1:0], lo_in[QB-1-j]};
    assign ge     = (rem_sh >= {1'b0, a_in});
    assign rem_d  = ge ? (rem_sh - {1'b0, a_in}) : rem_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= {quo_in[QB-2:0], ge};
        lo_q[j]  <= lo_in;
        a_q[j]   <= a_in;
        neg_q[j] <= neg_in;
        sat_q[j] <= sat_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j] <= '0;
      end else if (en_i) begin
        ctl_q[j] <= ctl_in;
      end
    end
  end

  // Sign, floor correction and saturation.
  logic [QB:0]   mag_up;
  logic [QB-1:0] mag_neg;
  logic signed [QB-1:0] dist_d;

  assign mag_up  = {1'b0, quo_q[QB-1]} + (QB+1)'(rem_q[QB-1] != '0);
  assign mag_neg = '0 - mag_up[QB-1:0];

  always_comb begin
    if (sat_q[QB-1]) begin
      dist_d = neg_q[QB-1] ? rsh_pkg::DIST_MIN : rsh_pkg::DIST_MAX;
    end else if (neg_q[QB-1]) begin
      dist_d = (mag_up >= ((QB+1)'(1) << (QB - 1))) ? rsh_pkg::DIST_MIN
                                                      : $signed(mag_neg);
    end else begin
      dist_d = quo_q[QB-1][QB-1] ? rsh_pkg::DIST_MAX : $signed(quo_q[QB-1]);
    end
  end

  logic signed [QB-1:0] dist_q;
  rsh_pkg::ctl_t        ctlo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctlo_q <= '0;
    end else if (en_i) begin
      ctlo_q <= ctl_q[QB-1];
    end
  end

  assign dist_o = dist_q;
  assign ctl_o  = ctlo_q;

endmodule

// ===== rtl/ray_sphere_hit_distance_core.sv =====
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   one ray: origin and direction
// m_axis    out        m_axis_tvalid/m_axis_tready   hit distance, hit flag in tuser
// cfg       in         cfg_we_i (no back-pressure)   sphere center and radius
//
// One ray enters per clock whenever the output is free to move. The
// one-bit-per-stage square root is the longest part of the pipeline.
// Reset clears all valid bits and loads the center with zero and the radius
// with 1.0. A result held at the output while m_axis_tready is low freezes
// the whole pipeline, so nothing is dropped or repeated.
`include "assert_macros.svh"

module ray_sphere_hit_distance_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_addr_i,
  input  logic [COORD_WIDTH-1:0]     cfg_wdata_i,
  // Ray requests.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z.
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Results.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Fields from bit 0 up: hit_distance.
  output logic [rsh_pkg::DIST_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: hit_flag.
  output logic [0:0]                 m_axis_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int OW  = CW + 1;          // center offsets
  localparam int PW  = 2 * CW + 3;      // A, H and C of the quadratic
  localparam int AW  = 2 * CW;          // A is unsigned and fits here
  localparam int QSW = 4 * CW + 4;      // nonnegative discriminant
  localparam int SW  = QSW / 2;
  localparam int NW  = PW + 2;          // root numerator
  localparam int L1  = (OW + 15) / 16;
  localparam int L2  = (PW + 15) / 16;

  // The whole pipeline moves together unless a result waits at the output.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration registers.
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [CW-2:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= (CW-1)'(32'd65536);
    end else if (cfg_we_i) begin
      case (rsh_pkg::cfg_idx_e'(cfg_addr_i))
        rsh_pkg::CFG_CENTER_X: cx_q  <= cfg_wdata_i;
        rsh_pkg::CFG_CENTER_Y: cy_q  <= cfg_wdata_i;
        rsh_pkg::CFG_CENTER_Z: cz_q  <= cfg_wdata_i;
        rsh_pkg::CFG_RADIUS:   rad_q <= cfg_wdata_i[CW-2:0];
        default: ;
      endcase
    end
  end

  // Stage 1: offsets from the sphere center.
  logic signed [OW-1:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q, rr_q;
  logic                 v1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= OW'($signed(s_axis_tdata[0*CW +: CW])) - OW'(cx_q);
      oy_q <= OW'($signed(s_axis_tdata[1*CW +: CW])) - OW'(cy_q);
      oz_q <= OW'($signed(s_axis_tdata[2*CW +: CW])) - OW'(cz_q);
      dx_q <= OW'($signed(s_axis_tdata[3*CW +: CW]));
      dy_q <= OW'($signed(s_axis_tdata[4*CW +: CW]));
      dz_q <= OW'($signed(s_axis_tdata[5*CW +: CW]));
      rr_q <= $signed({2'b00, rad_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  // First product bank: squares of direction, offset and radius, and the
  // direction-offset dot product terms.
  logic signed [OW-1:0]   ma [10];
  logic signed [OW-1:0]   mb [10];
  logic signed [2*OW-1:0] p1 [10];

  assign ma[0] = dx_q; assign mb[0] = dx_q;
  assign ma[1] = dy_q; assign mb[1] = dy_q;
  assign ma[2] = dz_q; assign mb[2] = dz_q;
  assign ma[3] = dx_q; assign mb[3] = ox_q;
  assign ma[4] = dy_q; assign mb[4] = oy_q;
  assign ma[5] = dz_q; assign mb[5] = oz_q;
  assign ma[6] = ox_q; assign mb[6] = ox_q;
  assign ma[7] = oy_q; assign mb[7] = oy_q;
  assign ma[8] = oz_q; assign mb[8] = oz_q;
  assign ma[9] = rr_q; assign mb[9] = rr_q;

  for (genvar k = 0; k < 10; k++) begin : g_mul1
    rsh_mul #(.AW(OW), .BW(OW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (ma[k]),
      .b_i   (mb[k]),
      .p_o   (p1[k])
    );
  end

  logic v1d;
  rsh_dly #(.W(1), .D(L1)) u_dly1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (v1_q),
    .d_o    (v1d)
  );

  // Stage 2: the three quadratic terms A, H and C.
  logic signed [PW-1:0] a2_q, h2_q, c2_q;
  logic                 v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q <= PW'(p1[0]) + PW'(p1[1]) + PW'(p1[2]);
      h2_q <= PW'(p1[3]) + PW'(p1[4]) + PW'(p1[5]);
      c2_q <= PW'(p1[6]) + PW'(p1[7]) + PW'(p1[8]) - PW'(p1[9]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1d;
    end
  end

  // Second product bank: H*H and A*C.
  logic signed [2*PW-1:0] hh, ac;

  rsh_mul #(.AW(PW), .BW(PW)) u_mul_hh (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (h2_q),
    .b_i   (h2_q),
    .p_o   (hh)
  );

  rsh_mul #(.AW(PW), .BW(PW)) u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a2_q),
    .b_i   (c2_q),
    .p_o   (ac)
  );

  logic [2*PW:0] side2;
  rsh_dly #(.W(2*PW+1), .D(L2)) u_dly2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({v2_q, h2_q, a2_q}),
    .d_o    (side2)
  );

  // Stage 3: discriminant and the miss decision. A negative discriminant
  // or a zero direction length is a miss.
  logic signed [2*PW-1:0] qd;
  logic signed [PW-1:0]   h2d, a2d;
  assign h2d = side2[2*PW-1:PW];
  assign a2d = side2[PW-1:0];
  assign qd  = hh - ac;

  logic [QSW-1:0]       q3_q;
  logic signed [PW-1:0] h3_q, a3_q;
  rsh_pkg::ctl_t        ctl3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_q <= qd[QSW-1:0];
      h3_q <= h2d;
      a3_q <= a2d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en) begin
      ctl3_q.valid <= side2[2*PW];
      ctl3_q.miss  <= (a2d == '0) || qd[2*PW-1];
    end
  end

  // Integer square root of the discriminant.
  logic [SW-1:0]     root;
  logic [2*PW+1:0]   side3;

  rsh_sqrt #(.QW(QSW), .XW(2*PW+2)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .q_i    (q3_q),
    .side_i ({ctl3_q, h3_q, a3_q}),
    .root_o (root),
    .side_o (side3)
  );

  // Stage 4: pick the near root numerator, or the far one when the near
  // root is negative.
  logic signed [NW-1:0] s_ext, h_ext, n_near, n_far;
  assign s_ext  = NW'(root);
  assign h_ext  = NW'($signed(side3[2*PW-1:PW]));
  assign n_near = -h_ext - s_ext;
  assign n_far  = -h_ext + s_ext;

  logic signed [NW-1:0] n4_q;
  logic [AW-1:0]        a4_q;
  rsh_pkg::ctl_t        ctl4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q <= n_near[NW-1] ? n_far : n_near;
      a4_q <= side3[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (en) begin
      ctl4_q <= side3[2*PW+1:2*PW];
    end
  end

  // Stage 5: sign and magnitude of the numerator.
  logic [NW-1:0] n4_abs;
  assign n4_abs = n4_q[NW-1] ? ('0 - n4_q) : n4_q;

  logic [PW-1:0] mag5_q;
  logic          neg5_q;
  logic [AW-1:0] a5_q;
  rsh_pkg::ctl_t ctl5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag5_q <= n4_abs[PW-1:0];
      neg5_q <= n4_q[NW-1];
      a5_q   <= a4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl5_q <= '0;
    end else if (en) begin
      ctl5_q <= ctl4_q;
    end
  end

  // Floor division by A with the fraction scaling and saturation.
  logic signed [rsh_pkg::DIST_W-1:0] div_dist;
  rsh_pkg::ctl_t                     ctl_div;

  rsh_div #(.NW(PW), .AW(AW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mag_i  (mag5_q),
    .neg_i  (neg5_q),
    .a_i    (a5_q),
    .ctl_i  (ctl5_q),
    .dist_o (div_dist),
    .ctl_o  (ctl_div)
  );

  // Output register.
  logic [rsh_pkg::DIST_W-1:0] dist_q;
  logic                       flag_q;
  logic                       out_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= ctl_div.miss ? rsh_pkg::MISS_DIST : div_dist;
      flag_q <= !ctl_div.miss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_div.valid;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = dist_q;
  assign m_axis_tuser[0] = flag_q;

  // A waiting result must hold off new requests.
  `RSH_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
  // A miss always carries the -1.0 distance.
  `RSH_ASSERT(a_miss_distance, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == rsh_pkg::MISS_DIST))
  // A radius write lands in the radius register on the next cycle.
  `RSH_ASSERT(a_radius_write, clk_i, rst_ni, (cfg_we_i && (cfg_addr_i == rsh_pkg::CFG_RADIUS)) |=> (rad_q == $past(cfg_wdata_i[CW-2:0])))

endmodule
